// ===== design/rps_pkg.sv =====
// Package for the timed relay pattern sequencer.
// Holds table sizing, field widths, the action codes and the result type.
// No dependencies.
package rps_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int LEN_W       = $clog2(TABLE_DEPTH + 1);
  localparam int CNT_W       = 17;
  localparam int RELAY_W     = 16;
  localparam int TIME_W      = 16;
  localparam int STEP_W      = 4;

  typedef enum logic [2:0] {
    ACT_TICK  = 3'd0,
    ACT_SET   = 3'd1,
    ACT_PAUSE = 3'd2,
    ACT_START = 3'd3,
    ACT_OFF   = 3'd4,
    ACT_WRITE = 3'd5,
    ACT_BEGIN = 3'd6,
    ACT_NOP   = 3'd7
  } action_t;

  typedef struct packed {
    logic [RELAY_W-1:0] relay_out;
    logic               running;
    logic [STEP_W-1:0]  current_step;
  } res_t;

endpackage

// ===== design/rps_if.sv =====
// Handshake channel interfaces for the relay pattern sequencer.
// Depends on rps_pkg for field widths.
interface rps_in_if import rps_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [2:0]         action;
  logic [RELAY_W-1:0] relay_word;
  logic [TIME_W-1:0]  step_time;
  logic [3:0]         slot;
  logic [4:0]         seq_count;

  modport source (output valid, action, relay_word, step_time, slot, seq_count,
                  input ready);
  modport sink (input valid, action, relay_word, step_time, slot, seq_count,
                output ready);
endinterface

interface rps_out_if import rps_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [RELAY_W-1:0] relay_out;
  logic               running;
  logic [STEP_W-1:0]  current_step;

  modport source (output valid, relay_out, running, current_step, input ready);
  modport sink (input valid, relay_out, running, current_step, output ready);
endinterface

// ===== design/timed_relay_pattern_sequencer_unit.sv =====
// Top level of the timed relay pattern sequencer.
// Depends on rps_pkg, rps_if, rps_core and rps_out_buf.
//
// Usage:
// in_bus carries one tick or command per beat (action, relay_word,
// step_time, slot, seq_count). out_bus returns exactly one result beat per
// input beat, in order: the relay pattern, the running flag and the step
// index as they stand after that input beat.
// A result is written into the result buffer when its input beat is taken
// and is presented on out_bus from there. Throughput is one beat per cycle
// while the receiver keeps out_bus.ready high; the step update is a single
// pass of logic over a 16-entry register table.
// A two-entry result buffer sits between the sequencer and out_bus. When the
// receiver stalls, one more input beat is still taken; in_bus.ready drops
// once both buffer entries hold results and rises again as they drain.
// Reset (rst_n low at a clock edge) clears the step table, the tick counter,
// the step index, the length, the relay pattern and the buffer at once; the
// block takes beats in the first cycle after reset.
module timed_relay_pattern_sequencer_unit import rps_pkg::*; (
  input logic   clk,
  input logic   rst_n,
  rps_in_if.sink    in_bus,
  rps_out_if.source out_bus
);

  logic fire;
  logic full;
  res_t res, out_data;

  assign in_bus.ready = !full;
  assign fire         = in_bus.valid && in_bus.ready;

  rps_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .action     (action_t'(in_bus.action)),
    .relay_word (in_bus.relay_word),
    .step_time  (in_bus.step_time),
    .slot       (in_bus.slot),
    .seq_count  (in_bus.seq_count),
    .res        (res)
  );

  rps_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fire),
    .push_data (res),
    .full      (full),
    .pop_valid (out_bus.valid),
    .pop_ready (out_bus.ready),
    .pop_data  (out_data)
  );

  assign out_bus.relay_out    = out_data.relay_out;
  assign out_bus.running      = out_data.running;
  assign out_bus.current_step = out_data.current_step;

  // Back-pressure on the input only comes from results that are waiting.
  a_ready_needs_backlog: assert property (@(posedge clk) disable iff (!rst_n)
    !in_bus.ready |-> out_bus.valid)
    else $error("input stalled with no result waiting");

  // A taken beat always leaves a result waiting on out_bus in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_bus.valid)
    else $error("accepted beat produced no result");

  // A begin-sequence beat restarts at step zero and runs.
  a_begin_runs: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (in_bus.action == ACT_BEGIN) |-> res.running && (res.current_step == '0))
    else $error("begin sequence did not start at step zero");

endmodule

// ===== design/rps_core.sv =====
// Sequencer state and per-beat update: step table, tick counter, step index,
// length and relay register. Depends on rps_pkg.
module rps_core import rps_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  action_t            action,
  input  logic [RELAY_W-1:0] relay_word,
  input  logic [TIME_W-1:0]  step_time,
  input  logic [3:0]         slot,
  input  logic [4:0]         seq_count,
  output res_t               res
);

  logic [RELAY_W-1:0] pat_r [TABLE_DEPTH];
  logic [TIME_W-1:0]  dur_r [TABLE_DEPTH];
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [IDX_W-1:0]   step_r, step_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic               active_r, active_nxt;
  logic [RELAY_W-1:0] relay_r, relay_nxt;

  logic [IDX_W-1:0]   step_inc;
  logic [LEN_W-1:0]   eff_len, last;
  logic [TIME_W-1:0]  dur;
  logic               wr_en;

  assign step_inc = IDX_W'(step_r + 1'b1);
  assign dur      = dur_r[step_r];
  assign wr_en    = fire && (action == ACT_WRITE) && (int'(slot) < TABLE_DEPTH);

  // A stored length of zero behaves as a single step; one above the table depth is clamped to it.
  always_comb begin
    eff_len = len_r;
    if (len_r == '0) eff_len = LEN_W'(1);
    if (int'(len_r) > TABLE_DEPTH) eff_len = LEN_W'(TABLE_DEPTH);
    last = eff_len - LEN_W'(1);
  end

  always_comb begin
    cnt_nxt    = cnt_r;
    step_nxt   = step_r;
    len_nxt    = len_r;
    active_nxt = active_r;
    relay_nxt  = relay_r;
    case (action)
      ACT_TICK: begin
        if (active_r) begin
          if (cnt_r != {CNT_W{1'b1}}) cnt_nxt = cnt_r + CNT_W'(1);
          if (cnt_r > CNT_W'(dur)) begin
            cnt_nxt = '0;
            if (LEN_W'(step_r) >= last) begin
              active_nxt = 1'b0;
            end else begin
              step_nxt  = step_inc;
              relay_nxt = pat_r[step_inc];
              if (LEN_W'(step_r) + LEN_W'(1) >= last) active_nxt = 1'b0;
            end
          end
        end
      end
      ACT_SET:   relay_nxt = relay_word;
      ACT_PAUSE: active_nxt = 1'b0;
      ACT_START: active_nxt = 1'b1;
      ACT_OFF: begin
        relay_nxt  = '0;
        active_nxt = 1'b0;
      end
      ACT_BEGIN: begin
        if (seq_count == '0) len_nxt = LEN_W'(1);
        else if (int'(seq_count) > TABLE_DEPTH) len_nxt = LEN_W'(TABLE_DEPTH);
        else len_nxt = LEN_W'(seq_count);
        cnt_nxt    = '0;
        step_nxt   = '0;
        relay_nxt  = pat_r[0];
        active_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      step_r   <= '0;
      len_r    <= '0;
      active_r <= 1'b0;
      relay_r  <= '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        pat_r[i] <= '0;
        dur_r[i] <= '0;
      end
    end else if (fire) begin
      cnt_r    <= cnt_nxt;
      step_r   <= step_nxt;
      len_r    <= len_nxt;
      active_r <= active_nxt;
      relay_r  <= relay_nxt;
      if (wr_en) begin
        pat_r[IDX_W'(slot)] <= relay_word;
        dur_r[IDX_W'(slot)] <= step_time;
      end
    end
  end

  // The result shows the state after the beat.
  assign res.relay_out    = relay_nxt;
  assign res.running      = active_nxt;
  assign res.current_step = STEP_W'(step_nxt);

endmodule

// ===== design/rps_out_buf.sv =====
// Two-entry result buffer that decouples the sequencer from a stalling
// receiver. Depends on rps_pkg for res_t.
module rps_out_buf import rps_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  res_t push_data,
  output logic full,
  output logic pop_valid,
  input  logic pop_ready,
  output res_t pop_data
);

  res_t       mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r, count_nxt;
  logic       pop;

  assign full      = (count_r == 2'd2);
  assign pop_valid = (count_r != 2'd0);
  assign pop       = pop_valid && pop_ready;
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 2'd1;
    else if (!push && pop) count_nxt = count_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop) rd_ptr_r <= ~rd_ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

// ===== sim/timed_relay_pattern_sequencer_unit_tb.sv =====
// Self-checking testbench for the timed relay pattern sequencer top level.
// Needs rps_pkg, rps_if and the design sources; a built-in predictor of the
// step table and tick counter scores every result beat in order.
module timed_relay_pattern_sequencer_unit_tb;
  import rps_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET    = 1650;
  localparam int HOLD_AT_RESULT = 400;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 10;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef struct packed {
    action_t            act;
    logic [RELAY_W-1:0] word;
    logic [TIME_W-1:0]  dur;
    logic [IDX_W-1:0]   slot;
    logic [LEN_W-1:0]   len;
  } relay_item_t;

  typedef struct {
    relay_item_t it;
    bit          typed;
    res_t        want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  rps_in_if  in_if ();
  rps_out_if out_if ();

  timed_relay_pattern_sequencer_unit u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_if),
    .out_bus (out_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state: step table, tick counter and sequencer registers.
  logic [RELAY_W-1:0] m_pat [TABLE_DEPTH];
  logic [TIME_W-1:0]  m_dur [TABLE_DEPTH];
  logic [CNT_W-1:0]   m_ticks;
  logic [IDX_W-1:0]   m_step;
  logic [LEN_W-1:0]   m_len;
  logic               m_run;
  logic [RELAY_W-1:0] m_relay;

  res_t     expected_relay_q [$];
  dir_row_t dir_rows [$];

  int  errs;
  int  n_items;
  int  n_results;
  int  n_starts;
  int  n_advances;
  int  n_in_stalled;
  int  idle_cycles;
  bit  no_gaps;
  bit  hold_done;

  function automatic res_t advance_sequencer(relay_item_t it);
    logic [CNT_W-1:0] prev_ticks;
    int               n;
    int               end_idx;
    case (it.act)
      ACT_TICK: begin
        if (m_run) begin
          prev_ticks = m_ticks;
          if (m_ticks != {CNT_W{1'b1}}) m_ticks = m_ticks + 1'b1;
          // The step ends on the tick after its count has passed the duration.
          if (prev_ticks > {1'b0, m_dur[m_step]}) begin
            n = int'(m_len);
            if (n == 0) n = 1;
            if (n > TABLE_DEPTH) n = TABLE_DEPTH;
            end_idx = n - 1;
            m_ticks = '0;
            if (int'(m_step) >= end_idx) begin
              m_run = 1'b0;
            end else begin
              m_step = m_step + 1'b1;
              m_relay = m_pat[m_step];
              n_advances++;
              if (int'(m_step) >= end_idx) m_run = 1'b0;
            end
          end
        end
      end
      ACT_SET: m_relay = it.word;
      ACT_PAUSE: m_run = 1'b0;
      ACT_START: m_run = 1'b1;
      ACT_OFF: begin
        m_relay = '0;
        m_run = 1'b0;
      end
      ACT_WRITE: begin
        // A four-bit slot always falls inside the sixteen-entry table.
        m_pat[it.slot] = it.word;
        m_dur[it.slot] = it.dur;
      end
      ACT_BEGIN: begin
        n = int'(it.len);
        if (n == 0) n = 1;
        if (n > TABLE_DEPTH) n = TABLE_DEPTH;
        m_len = LEN_W'(n);
        m_ticks = '0;
        m_step = '0;
        m_relay = m_pat[0];
        m_run = 1'b1;
        n_starts++;
      end
      default: ;
    endcase
    return '{relay_out: m_relay, running: m_run, current_step: m_step};
  endfunction

  function automatic void add_row(action_t a, logic [RELAY_W-1:0] w, logic [TIME_W-1:0] d,
                                  logic [IDX_W-1:0] s, logic [LEN_W-1:0] l, bit typed,
                                  res_t want);
    dir_row_t r;
    r.it = '{act: a, word: w, dur: d, slot: s, len: l};
    r.typed = typed;
    r.want = want;
    dir_rows.push_back(r);
  endfunction

  // Most gaps are short, a few are long, and inside quiet windows there are none.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps) return 0;
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Short durations let sequences run through many steps.
  function automatic logic [TIME_W-1:0] pick_dur();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return TIME_W'($urandom_range(0, 3));
    if (r < 95) return TIME_W'($urandom_range(4, 12));
    return TIME_W'($urandom);
  endfunction

  function automatic relay_item_t rand_item(action_t a);
    relay_item_t it;
    int r;
    r = $urandom_range(0, 9);
    it.act = a;
    it.word = RELAY_W'($urandom);
    it.dur = pick_dur();
    it.slot = IDX_W'($urandom_range(0, TABLE_DEPTH - 1));
    if (r == 0) it.len = '0;
    else if (r == 1) it.len = LEN_W'($urandom_range(TABLE_DEPTH + 1, 31));
    else it.len = LEN_W'($urandom_range(1, TABLE_DEPTH));
    return it;
  endfunction

  task automatic send_item(input relay_item_t it, input bit typed, input res_t want);
    int   g;
    res_t pred;
    g = pick_gap();
    repeat (g) begin
      @(negedge clk);
      in_if.valid = 1'b0;
    end
    @(negedge clk);
    in_if.action = it.act;
    in_if.relay_word = it.word;
    in_if.step_time = it.dur;
    in_if.slot = it.slot;
    in_if.seq_count = it.len;
    in_if.valid = 1'b1;
    do @(posedge clk); while (!in_if.ready);
    pred = advance_sequencer(it);
    expected_relay_q.push_back(typed ? want : pred);
    n_items++;
  endtask

  // Result scoreboard.
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      n_results++;
      if (expected_relay_q.size() == 0) begin
        errs++;
        $display("%0t: unexpected result beat: relay_out %h running %b current_step %0d",
                 $time, out_if.relay_out, out_if.running, out_if.current_step);
      end else begin
        want = expected_relay_q.pop_front();
        if (out_if.relay_out !== want.relay_out) begin
          errs++;
          $display("%0t: relay_out expected %h, got %h", $time, want.relay_out,
                   out_if.relay_out);
        end
        if (out_if.running !== want.running) begin
          errs++;
          $display("%0t: running expected %b, got %b", $time, want.running, out_if.running);
        end
        if (out_if.current_step !== want.current_step) begin
          errs++;
          $display("%0t: current_step expected %0d, got %0d", $time, want.current_step,
                   out_if.current_step);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if (in_if.valid && !in_if.ready) n_in_stalled <= n_in_stalled + 1;
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off that backs up the input.
  initial begin
    int stall;
    stall = 0;
    out_if.ready = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      if (!hold_done && n_results >= HOLD_AT_RESULT) begin
        hold_done = 1'b1;
        stall = HOLD_CYCLES;
      end else if (stall == 0 && $urandom_range(0, 7) == 0) begin
        stall = pick_gap();
      end
      if (stall > 0) begin
        out_if.ready = 1'b0;
        stall--;
      end else begin
        out_if.ready = 1'b1;
      end
      @(negedge clk);
    end
  end

  initial begin
    relay_item_t it;
    action_t     a;
    int          n_dir;
    in_if.valid = 1'b0;
    in_if.action = ACT_NOP;
    in_if.relay_word = '0;
    in_if.step_time = '0;
    in_if.slot = '0;
    in_if.seq_count = '0;
    rst_n = 1'b0;
    errs = 0;
    n_items = 0;
    n_results = 0;
    n_starts = 0;
    n_advances = 0;
    n_in_stalled = 0;
    no_gaps = 1'b0;
    hold_done = 1'b0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      m_pat[i] = '0;
      m_dur[i] = '0;
    end
    m_ticks = '0;
    m_step = '0;
    m_len = '0;
    m_run = 1'b0;
    m_relay = '0;

    // Tick while stopped, ignored no-op, relay extremes.
    add_row(ACT_TICK, '0, '0, '0, '0, 1, '{16'h0000, 1'b0, 4'd0});
    add_row(ACT_NOP, 16'hFFFF, 16'hFFFF, 4'd15, 5'd31, 1, '{16'h0000, 1'b0, 4'd0});
    add_row(ACT_SET, 16'hFFFF, '0, '0, '0, 1, '{16'hFFFF, 1'b0, 4'd0});
    // Start before any sequence acts as a one-step sequence.
    add_row(ACT_START, 16'h0000, '0, '0, '0, 1, '{16'hFFFF, 1'b1, 4'd0});
    add_row(ACT_TICK, '0, '0, '0, '0, 1, '{16'hFFFF, 1'b1, 4'd0});
    add_row(ACT_TICK, '0, '0, '0, '0, 1, '{16'hFFFF, 1'b0, 4'd0});
    add_row(ACT_WRITE, 16'h00FF, 16'd0, 4'd0, '0, 1, '{16'hFFFF, 1'b0, 4'd0});
    add_row(ACT_WRITE, 16'h0F0F, 16'd1, 4'd1, '0, 0, '0);
    add_row(ACT_WRITE, 16'hFFFF, 16'hFFFF, 4'd15, '0, 0, '0);
    // Zero length is taken as one step.
    add_row(ACT_BEGIN, '0, '0, '0, 5'd0, 1, '{16'h00FF, 1'b1, 4'd0});
    add_row(ACT_TICK, '0, '0, '0, '0, 0, '0);
    add_row(ACT_TICK, '0, '0, '0, '0, 1, '{16'h00FF, 1'b0, 4'd0});
    // An oversized length saturates at the table depth.
    add_row(ACT_BEGIN, '0, '0, '0, 5'd31, 1, '{16'h00FF, 1'b1, 4'd0});
    add_row(ACT_TICK, '0, '0, '0, '0, 0, '0);
    add_row(ACT_TICK, '0, '0, '0, '0, 0, '0);
    add_row(ACT_PAUSE, '0, '0, '0, '0, 0, '0);
    add_row(ACT_START, '0, '0, '0, '0, 0, '0);
    add_row(ACT_OFF, '0, '0, '0, '0, 1, '{16'h0000, 1'b0, 4'd1});
    add_row(ACT_BEGIN, '0, '0, '0, 5'd2, 0, '0);
    add_row(ACT_TICK, '0, '0, '0, '0, 0, '0);
    add_row(ACT_TICK, '0, '0, '0, '0, 0, '0);
    // A start at the last step runs out its duration and stops in place.
    add_row(ACT_START, '0, '0, '0, '0, 0, '0);
    add_row(ACT_TICK, '0, '0, '0, '0, 0, '0);
    add_row(ACT_TICK, '0, '0, '0, '0, 0, '0);
    add_row(ACT_TICK, '0, '0, '0, '0, 0, '0);
    n_dir = dir_rows.size();

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i]) send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);

    while (n_items < ITEM_TARGET) begin
      no_gaps = (n_items >= 700 && n_items < 900);
      if ($urandom_range(0, 9) == 0) begin
        // Unstructured noise with full-range fields.
        repeat (20) begin
          it = rand_item(action_t'($urandom_range(0, 7)));
          it.dur = TIME_W'($urandom);
          send_item(it, 0, '0);
        end
      end else begin
        repeat ($urandom_range(1, 6)) send_item(rand_item(ACT_WRITE), 0, '0);
        send_item(rand_item(ACT_BEGIN), 0, '0);
        repeat ($urandom_range(5, 60)) begin
          if ($urandom_range(0, 99) < 85) a = ACT_TICK;
          else a = action_t'($urandom_range(1, 7));
          send_item(rand_item(a), 0, '0);
        end
      end
    end

    @(negedge clk);
    in_if.valid = 1'b0;
    while (expected_relay_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d input beats (%0d directed) and %0d result beats.",
             n_items, n_dir, n_results);
    $display("Sequences started: %0d, step advances: %0d, input stalled for %0d cycles.",
             n_starts, n_advances, n_in_stalled);
    if (errs == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
